### sv/fst_pkg.sv
// Shared types and constants for the suffix-form binary indexed tree.
// Used by fst_front, fst_queue, fst_back and fenwick_suffix_sum_tree.
package fst_pkg;

    localparam int POS_W   = 11;
    localparam int WALK_W  = POS_W + 1;
    localparam int VALUE_W = 64;
    localparam int QDEPTH  = 2;
    localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_QUERY,
        OP_ERROR,
        OP_EMPTY
    } op_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_WALK,
        B_EMIT
    } back_state_t;

    typedef struct packed {
        op_t                        op;
        logic [POS_W-1:0]           pos;
        logic [POS_W-1:0]           size;
        logic signed [VALUE_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_out_t;

endpackage

### sv/fst_front.sv
// Front end: size register, item acceptance and classification.
// Depends on fst_pkg; pushes classified items into fst_queue.
module fst_front #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fst_pkg::POS_W-1:0]          cfg_data,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               command,
    input  logic [fst_pkg::POS_W-1:0]          position,
    input  logic signed [fst_pkg::VALUE_W-1:0] value,
    input  logic                               clearing,
    input  logic                               q_full,
    output logic                               q_push,
    output fst_pkg::item_t                     q_item
);

    localparam int POS_LIMIT = (1 << fst_pkg::POS_W) - 1;
    localparam int MAX_N_INT = (MAX_POSITIONS < POS_LIMIT) ? MAX_POSITIONS : POS_LIMIT;
    localparam logic [fst_pkg::POS_W-1:0] MAX_N = fst_pkg::POS_W'(MAX_N_INT);

    logic [fst_pkg::POS_W-1:0] size_reg;
    logic [fst_pkg::POS_W-1:0] size_next;
    logic [fst_pkg::POS_W-1:0] n_active;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        size_next = size_reg;
        if (cfg_valid && cfg_ready)
        begin
            size_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= fst_pkg::SIZE_RESET;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    assign n_active  = (size_reg > MAX_N) ? MAX_N : size_reg;
    assign req_stall = clearing || q_full;
    assign q_push    = req_valid && !req_stall;

    always_comb
    begin
        q_item.pos   = position;
        q_item.size  = n_active;
        q_item.value = value;
        if (position == '0)
        begin
            q_item.op = fst_pkg::OP_ERROR;
        end
        else if (position > n_active)
        begin
            q_item.op = command ? fst_pkg::OP_EMPTY : fst_pkg::OP_ERROR;
        end
        else
        begin
            q_item.op = command ? fst_pkg::OP_QUERY : fst_pkg::OP_ADD;
        end
    end

endmodule

### sv/fst_queue.sv
// Two-entry item queue between the front end and the walk engine.
// Depends on fst_pkg for the item type.
module fst_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fst_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output fst_pkg::q_out_t head
);

    localparam int PTR_W = $clog2(fst_pkg::QDEPTH);
    localparam int CNT_W = $clog2(fst_pkg::QDEPTH + 1);

    fst_pkg::item_t   entries_reg [fst_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(fst_pkg::QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(fst_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(fst_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### sv/fst_back.sv
// Walk engine: cell memory, clearing pass, add and query walks, result register.
// Depends on fst_pkg; takes items from fst_queue.
module fst_back #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fst_pkg::q_out_t                     head,
    output logic                                q_pop,
    output logic                                clearing,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic signed [fst_pkg::VALUE_W-1:0]  sum,
    output logic                                status
);

    localparam int AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

    logic [fst_pkg::VALUE_W-1:0] cells_mem [MAX_POSITIONS];

    fst_pkg::back_state_t state_reg;
    fst_pkg::back_state_t state_next;

    logic [AW-1:0]                  clr_reg;
    logic [AW-1:0]                  clr_next;
    fst_pkg::op_t                   op_reg;
    fst_pkg::op_t                   op_next;
    logic [fst_pkg::WALK_W-1:0]     i_reg;
    logic [fst_pkg::WALK_W-1:0]     i_next;
    logic [fst_pkg::POS_W-1:0]      n_reg;
    logic [fst_pkg::POS_W-1:0]      n_next;
    logic [fst_pkg::VALUE_W-1:0]    value_reg;
    logic [fst_pkg::VALUE_W-1:0]    value_next;
    logic [fst_pkg::VALUE_W-1:0]    acc_reg;
    logic [fst_pkg::VALUE_W-1:0]    acc_next;
    logic                           pend_reg;
    logic                           pend_next;
    logic [AW-1:0]                  pend_addr_reg;
    logic [AW-1:0]                  pend_addr_next;
    logic [fst_pkg::VALUE_W-1:0]    rd_data_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [fst_pkg::VALUE_W-1:0]    out_sum_reg;
    logic [fst_pkg::VALUE_W-1:0]    out_sum_next;
    logic                           out_status_reg;
    logic                           out_status_next;

    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [fst_pkg::VALUE_W-1:0]    wr_data;
    logic                           issue;
    logic [fst_pkg::WALK_W-1:0]     low_bit;

    assign clearing  = (state_reg == fst_pkg::B_CLEAR);
    assign rsp_valid = out_valid_reg;
    assign sum       = out_sum_reg;
    assign status    = out_status_reg;
    assign low_bit   = i_reg & (~i_reg + 1'b1);

    always_comb
    begin
        if (op_reg == fst_pkg::OP_ADD)
        begin
            issue = (i_reg != '0);
        end
        else
        begin
            issue = (i_reg <= {1'b0, n_reg});
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        i_next          = i_reg;
        n_next          = n_reg;
        value_next      = value_reg;
        acc_next        = acc_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = AW'(i_reg - 1'b1);
        wr_en           = 1'b0;
        wr_addr         = pend_addr_reg;
        wr_data         = rd_data_reg + value_reg;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fst_pkg::B_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = fst_pkg::B_IDLE;
                end
            end
            fst_pkg::B_IDLE:
            begin
                if (head.valid)
                begin
                    q_pop      = 1'b1;
                    op_next    = head.item.op;
                    i_next     = {1'b0, head.item.pos};
                    n_next     = head.item.size;
                    value_next = head.item.value;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    if (head.item.op == fst_pkg::OP_ADD || head.item.op == fst_pkg::OP_QUERY)
                    begin
                        state_next = fst_pkg::B_WALK;
                    end
                    else
                    begin
                        state_next = fst_pkg::B_EMIT;
                    end
                end
            end
            fst_pkg::B_WALK:
            begin
                pend_next = issue;
                if (issue)
                begin
                    rd_en          = 1'b1;
                    pend_addr_next = rd_addr;
                    if (op_reg == fst_pkg::OP_ADD)
                    begin
                        i_next = i_reg - low_bit;
                    end
                    else
                    begin
                        i_next = i_reg + low_bit;
                    end
                end
                if (pend_reg)
                begin
                    if (op_reg == fst_pkg::OP_ADD)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_reg + rd_data_reg;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = fst_pkg::B_EMIT;
                end
            end
            fst_pkg::B_EMIT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_sum_next    = acc_reg;
                    out_status_next = (op_reg == fst_pkg::OP_ERROR);
                    state_next      = fst_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = fst_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fst_pkg::B_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        i_reg          <= i_next;
        n_reg          <= n_next;
        value_reg      <= value_next;
        acc_reg        <= acc_next;
        pend_addr_reg  <= pend_addr_next;
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cells_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cells_mem[rd_addr];
        end
    end

endmodule

### sv/fenwick_suffix_sum_tree.sv
// Top level of the suffix-form binary indexed tree: front end, queue, walk engine.
// Depends on fst_pkg, fst_front, fst_queue and fst_back.
//
//  channel | valid     | flow ctl  | payload
//  --------+-----------+-----------+------------------------
//  req     | req_valid | req_stall | command, position, value
//  rsp     | rsp_valid | rsp_stall | sum, status
//  cfg     | cfg_valid | cfg_ready | cfg_data (size_in_use)
//
// An item's walk from acceptance to rsp_valid visits one cell at a time:
// popcount(position) cells for an add, up to log2 of the size plus one for a query;
// errors and queries above the size visit no cell. The single read port and single
// write port of the cell memory set that pace.
// After reset a clearing pass zeroes all MAX_POSITIONS cells; req_stall
// stays high during it. The queue holds two items, so req_stall rises only once
// both are waiting; a valid result holds in its register while rsp_stall is high.
module fenwick_suffix_sum_tree #(
    parameter int MAX_POSITIONS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fst_pkg::POS_W-1:0]          cfg_data,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               command,
    input  logic [fst_pkg::POS_W-1:0]          position,
    input  logic signed [fst_pkg::VALUE_W-1:0] value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic signed [fst_pkg::VALUE_W-1:0] sum,
    output logic                               status
);

    logic            clearing;
    logic            q_full;
    logic            q_push;
    logic            q_pop;
    fst_pkg::item_t  q_item;
    fst_pkg::q_out_t q_head;

    fst_front #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .command   (command),
        .position  (position),
        .value     (value),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    fst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    fst_back #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sum       (sum),
        .status    (status)
    );

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> req_stall)
        else $error("item accepted during clearing pass");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("walk engine popped an empty queue");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status) |-> (sum == '0))
        else $error("error result carries a nonzero sum");

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into a full queue");

endmodule
